@@ hw/rtl/nbfs_pkg.sv @@
// shared types, codes and helpers of the gravity frame stepper
package nbfs_pkg;

    // body index field width and most results one frame reports
    localparam int IDX_W   = 3;
    localparam int RES_CAP = 8;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_MIN_DIST = 3'd2,
        REG_DAMPING  = 3'd3,
        REG_COUNT    = 3'd4
    } t_reg;

    // datapath micro operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_LDI,
        OP_LDJ,
        OP_MUL_SQX,
        OP_MUL_SQY,
        OP_ADD_S,
        OP_MUL_MD,
        OP_SAVE_MD,
        OP_MUL_RR,
        OP_SQRT,
        OP_DIV_C,
        OP_MUL_MUV,
        OP_DIV_P,
        OP_DIV_Q,
        OP_APPLY,
        OP_MOVE,
        OP_MUL_DAMP,
        OP_BNC,
        OP_STORE,
        OP_EMIT
    } t_op;

    // velocity that a bounce works on
    typedef enum logic [1:0] {
        TGT_WVX = 2'd0,
        TGT_WVY = 2'd1,
        TGT_JVX = 2'd2,
        TGT_JVY = 2'd3
    } t_tgt;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] addr;
        t_tgt             tgt;
        logic             axis;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic pull_ok;
        logic hit;
        logic wall_x;
        logic wall_y;
        logic sqrt_busy;
        logic div_busy;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [30:0] min_dist;
        logic [15:0] damping;
        logic [3:0]  count;
    } t_cfg;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = $signed(34'h3_8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return $signed(32'h8000_0000);
        end
        return v[31:0];
    endfunction

endpackage

@@ hw/rtl/nbfs_sqrt.sv @@
// bit-serial integer square root, two radicand bits per cycle
module nbfs_sqrt
    import nbfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_rad,
    output logic        o_busy,
    output logic [32:0] o_root
);
    localparam logic [5:0] STEPS = 6'd33;

    logic [65:0] r_rad;
    logic [33:0] r_rem;
    logic [32:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;

    logic [35:0] w_rem;
    logic [35:0] w_trial;
    logic [35:0] w_diff;
    logic        w_ge;

    // trial subtract of (4*root + 1)
    always_comb begin
        w_rem   = {r_rem, r_rad[65:64]};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = (w_rem >= w_trial);
        w_diff  = w_rem - w_trial;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEPS;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[63:0], 2'b00};
            r_rem  <= w_ge ? w_diff[33:0] : w_rem[33:0];
            r_root <= {r_root[31:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

@@ hw/rtl/nbfs_div.sv @@
// restoring divider, 64-bit dividend by 33-bit divisor, one bit per cycle
module nbfs_div
    import nbfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [32:0] i_divisor,
    output logic        o_busy,
    output logic [63:0] o_quot
);
    localparam logic [6:0] STEPS = 7'd64;

    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [32:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;

    logic [33:0] w_rem;
    logic [33:0] w_diff;
    logic        w_ge;

    // shift in one dividend bit and try the subtract
    always_comb begin
        w_rem  = {r_rem, r_q[63]};
        w_ge   = (w_rem >= {1'b0, r_d});
        w_diff = w_rem - {1'b0, r_d};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEPS;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient shifts in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], w_ge};
            r_rem <= w_ge ? w_diff[32:0] : w_rem[32:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

@@ hw/rtl/nbfs_datapath.sv @@
// body store, working registers, shared multiplier, root and divide units
module nbfs_datapath
    import nbfs_pkg::*;
#(
    parameter int BODY_SLOTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_cfg               i_cfg,
    output t_stat              o_stat,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic [30:0]        i_body_radius,
    input  logic [31:0]        i_pull,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [2:0]         o_out_index,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_vel_x,
    output logic signed [31:0] o_out_vel_y,
    output logic               o_last_body
);
    localparam int IW = (BODY_SLOTS > 1) ? $clog2(BODY_SLOTS) : 1;

    // body store
    logic signed [31:0] r_px [BODY_SLOTS];
    logic signed [31:0] r_py [BODY_SLOTS];
    logic signed [31:0] r_vx [BODY_SLOTS];
    logic signed [31:0] r_vy [BODY_SLOTS];
    logic [30:0]        r_sz [BODY_SLOTS];
    logic [31:0]        r_mu [BODY_SLOTS];

    // working body and pair registers
    logic signed [31:0] r_wpx, r_wpy, r_wvx, r_wvy;
    logic [30:0]        r_wsz;
    logic [32:0]        r_mdx, r_mdy;
    logic               r_negx, r_negy, r_nzx, r_nzy;
    logic [31:0]        r_pmu;
    logic [31:0]        r_rr;
    logic [65:0]        r_s;
    logic [61:0]        r_md2;
    logic [65:0]        r_prod;
    logic               r_out_valid;

    logic [IW-1:0]      w_ix;
    logic signed [31:0] w_apx, w_apy, w_avx, w_avy;
    logic [30:0]        w_asz;
    logic signed [32:0] w_dx, w_dy;
    logic [32:0]        w_ma, w_mb;
    logic [65:0]        w_prod;
    logic               w_mul;
    logic signed [31:0] w_tv;
    logic signed [32:0] w_tvx;
    logic [32:0]        w_tmag;
    logic [32:0]        w_m;
    logic signed [31:0] w_bnc;
    logic [32:0]        w_root;
    logic [63:0]        w_quot;
    logic [63:0]        w_dvd;
    logic               w_div_go;
    logic               w_sq_busy, w_dv_busy;
    logic [31:0]        w_a;
    logic signed [31:0] w_avel;
    logic signed [31:0] w_newv;
    logic               w_cneg, w_cnz;
    logic signed [33:0] w_tx, w_ty;
    logic signed [33:0] w_wlim, w_hlim;
    logic signed [31:0] w_lx1, w_lx2, w_ly1, w_ly2;

    assign w_ix  = i_cmd.addr[IW-1:0];
    assign w_apx = r_px[w_ix];
    assign w_apy = r_py[w_ix];
    assign w_avx = r_vx[w_ix];
    assign w_avy = r_vy[w_ix];
    assign w_asz = r_sz[w_ix];

    // pair offset; its magnitude is taken when the pair is loaded
    always_comb begin
        w_dx = {r_wpx[31], r_wpx} - {w_apx[31], w_apx};
        w_dy = {r_wpy[31], r_wpy} - {w_apy[31], w_apy};
    end

    // velocity chosen for a bounce
    always_comb begin
        unique case (i_cmd.tgt)
            TGT_WVX: w_tv = r_wvx;
            TGT_WVY: w_tv = r_wvy;
            TGT_JVX: w_tv = w_avx;
            TGT_JVY: w_tv = w_avy;
            default: w_tv = r_wvx;
        endcase
        w_tvx  = {w_tv[31], w_tv};
        w_tmag = w_tv[31] ? 33'(-w_tvx) : 33'(w_tvx);
        w_m    = r_prod[47:15];
        w_bnc  = w_tv[31] ? sat32({1'b0, w_m}) : sat32(-$signed({1'b0, w_m}));
    end

    // shared multiplier operand select
    always_comb begin
        w_ma  = '0;
        w_mb  = '0;
        w_mul = 1'b1;
        unique case (i_cmd.op)
            OP_MUL_SQX:  begin w_ma = r_mdx; w_mb = r_mdx; end
            OP_MUL_SQY:  begin w_ma = r_mdy; w_mb = r_mdy; end
            OP_MUL_MD:   begin w_ma = {2'b00, i_cfg.min_dist}; w_mb = {2'b00, i_cfg.min_dist}; end
            OP_MUL_MUV:  begin w_ma = {1'b0, r_pmu}; w_mb = {16'h0, w_quot[16:0]}; end
            OP_MUL_RR:   begin w_ma = {1'b0, r_rr}; w_mb = {1'b0, r_rr}; end
            OP_MUL_DAMP: begin w_ma = w_tmag; w_mb = {17'h0, i_cfg.damping}; end
            default:     w_mul = 1'b0;
        endcase
        w_prod = w_ma * w_mb;
    end

    // divider dividend select
    always_comb begin
        w_div_go = 1'b1;
        unique case (i_cmd.op)
            OP_DIV_C: w_dvd = {15'h0, (i_cmd.axis ? r_mdy : r_mdx), 16'h0};
            OP_DIV_P: w_dvd = {15'h0, r_prod[48:0]};
            OP_DIV_Q: w_dvd = {w_quot[47:0], 16'h0};
            default: begin
                w_dvd    = '0;
                w_div_go = 1'b0;
            end
        endcase
    end

    nbfs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT),
        .i_rad   (r_s),
        .o_busy  (w_sq_busy),
        .o_root  (w_root)
    );

    nbfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_go),
        .i_dividend (w_dvd),
        .i_divisor  (w_root),
        .o_busy     (w_dv_busy),
        .o_quot     (w_quot)
    );

    // pull applied to one velocity component, capped at 2^31
    always_comb begin
        w_a    = (w_quot > 64'h8000_0000) ? 32'h8000_0000 : w_quot[31:0];
        w_avel = i_cmd.axis ? r_wvy : r_wvx;
        w_cneg = i_cmd.axis ? r_negy : r_negx;
        w_cnz  = i_cmd.axis ? r_nzy : r_nzx;
        if (!w_cnz) begin
            w_newv = w_avel;
        end else if (w_cneg) begin
            w_newv = sat32({{2{w_avel[31]}}, w_avel} + $signed({2'b00, w_a}));
        end else begin
            w_newv = sat32({{2{w_avel[31]}}, w_avel} - $signed({2'b00, w_a}));
        end
    end

    // wall tests on the moved body
    always_comb begin
        w_tx   = {{2{r_wpx[31]}}, r_wpx} + $signed({3'b000, r_wsz});
        w_ty   = {{2{r_wpy[31]}}, r_wpy} + $signed({3'b000, r_wsz});
        w_wlim = $signed({2'b00, i_cfg.width, 16'h0});
        w_hlim = $signed({2'b00, i_cfg.height, 16'h0});
    end

    // load nudge off an exact edge
    always_comb begin
        if ({i_pos_x[31], i_pos_x} == {1'b0, i_cfg.width, 16'h0}) begin
            w_lx1 = sat32({{2{i_pos_x[31]}}, i_pos_x} - $signed({3'b000, i_body_radius}));
        end else begin
            w_lx1 = i_pos_x;
        end
        w_lx2 = (w_lx1 == 32'sd0) ? $signed({1'b0, i_body_radius}) : w_lx1;
        if ({i_pos_y[31], i_pos_y} == {1'b0, i_cfg.height, 16'h0}) begin
            w_ly1 = sat32({{2{i_pos_y[31]}}, i_pos_y} - $signed({3'b000, i_body_radius}));
        end else begin
            w_ly1 = i_pos_y;
        end
        w_ly2 = (w_ly1 == 32'sd0) ? $signed({1'b0, i_body_radius}) : w_ly1;
    end

    // body store writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BODY_SLOTS; k++) begin
                r_px[k] <= '0;
                r_py[k] <= '0;
                r_vx[k] <= '0;
                r_vy[k] <= '0;
                r_sz[k] <= '0;
                r_mu[k] <= '0;
            end
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_px[w_ix] <= w_lx2;
                    r_py[w_ix] <= w_ly2;
                    r_vx[w_ix] <= i_vel_x;
                    r_vy[w_ix] <= i_vel_y;
                    r_sz[w_ix] <= i_body_radius;
                    r_mu[w_ix] <= i_pull;
                end
                OP_STORE: begin
                    r_px[w_ix] <= r_wpx;
                    r_py[w_ix] <= r_wpy;
                    r_vx[w_ix] <= r_wvx;
                    r_vy[w_ix] <= r_wvy;
                end
                OP_BNC: begin
                    if (i_cmd.tgt == TGT_JVX) begin
                        r_vx[w_ix] <= w_bnc;
                    end else if (i_cmd.tgt == TGT_JVY) begin
                        r_vy[w_ix] <= w_bnc;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_mul) begin
            r_prod <= w_prod;
        end
        unique case (i_cmd.op)
            OP_LDI: begin
                r_wpx <= w_apx;
                r_wpy <= w_apy;
                r_wvx <= w_avx;
                r_wvy <= w_avy;
                r_wsz <= w_asz;
            end
            OP_LDJ: begin
                r_mdx  <= w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
                r_mdy  <= w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
                r_negx <= w_dx[32];
                r_negy <= w_dy[32];
                r_nzx  <= (w_dx != 33'sd0);
                r_nzy  <= (w_dy != 33'sd0);
                r_pmu  <= r_mu[w_ix];
                r_rr   <= {1'b0, r_wsz} + {1'b0, w_asz};
            end
            OP_MUL_SQY: r_s   <= r_prod;
            OP_ADD_S:   r_s   <= r_s + r_prod;
            OP_SAVE_MD: r_md2 <= r_prod[61:0];
            OP_APPLY: begin
                if (i_cmd.axis) begin
                    r_wvy <= w_newv;
                end else begin
                    r_wvx <= w_newv;
                end
            end
            OP_MOVE: begin
                r_wpx <= sat32({{2{r_wpx[31]}}, r_wpx} + {{2{r_wvx[31]}}, r_wvx});
                r_wpy <= sat32({{2{r_wpy[31]}}, r_wpy} + {{2{r_wvy[31]}}, r_wvy});
            end
            OP_BNC: begin
                if (i_cmd.tgt == TGT_WVX) begin
                    r_wvx <= w_bnc;
                end else if (i_cmd.tgt == TGT_WVY) begin
                    r_wvy <= w_bnc;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            o_out_index <= i_cmd.addr;
            o_out_pos_x <= w_apx;
            o_out_pos_y <= w_apy;
            o_out_vel_x <= w_avx;
            o_out_vel_y <= w_avy;
            o_last_body <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;

    // status back to the controller
    always_comb begin
        o_stat.pull_ok   = (r_s != '0) && (r_s >= {4'h0, r_md2});
        o_stat.hit       = (r_s <= r_prod);
        o_stat.wall_x    = (w_tx <= 34'sd0) || (w_tx >= w_wlim);
        o_stat.wall_y    = (w_ty <= 34'sd0) || (w_ty >= w_hlim);
        o_stat.sqrt_busy = w_sq_busy;
        o_stat.div_busy  = w_dv_busy;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

endmodule

@@ hw/rtl/nbfs_ctrl.sv @@
// frame sequencer: walks loads, pair pulls, moves, walls, collisions, results
module nbfs_ctrl
    import nbfs_pkg::*;
#(
    parameter int BODY_SLOTS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_action,
    input  logic [IDX_W-1:0] i_body_index,
    input  logic [3:0]       i_count,
    input  t_stat            i_stat,
    output logic             o_ready,
    output t_cmd             o_cmd
);
    localparam int CW = $clog2(BODY_SLOTS + 1);

    typedef enum logic [30:0] {
        S_IDLE  = 31'h1 << 0,
        S_MD    = 31'h1 << 1,
        S_MD2   = 31'h1 << 2,
        S_GI    = 31'h1 << 3,
        S_GJ    = 31'h1 << 4,
        S_SQX   = 31'h1 << 5,
        S_SQY   = 31'h1 << 6,
        S_SSUM  = 31'h1 << 7,
        S_CHK   = 31'h1 << 8,
        S_CCHK  = 31'h1 << 9,
        S_SQRT  = 31'h1 << 10,
        S_DVC   = 31'h1 << 11,
        S_DVCW  = 31'h1 << 12,
        S_MUV   = 31'h1 << 13,
        S_DVP   = 31'h1 << 14,
        S_DVPW  = 31'h1 << 15,
        S_DVQ   = 31'h1 << 16,
        S_DVQW  = 31'h1 << 17,
        S_APPLY = 31'h1 << 18,
        S_MOVE  = 31'h1 << 19,
        S_WALLY = 31'h1 << 20,
        S_BNCY  = 31'h1 << 21,
        S_WALLX = 31'h1 << 22,
        S_BNCX  = 31'h1 << 23,
        S_WBI   = 31'h1 << 24,
        S_CI    = 31'h1 << 25,
        S_CJ    = 31'h1 << 26,
        S_CBM   = 31'h1 << 27,
        S_CBW   = 31'h1 << 28,
        S_CWB   = 31'h1 << 29,
        S_EMIT  = 31'h1 << 30
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_n, n_n;
    logic          r_coll, n_coll;
    logic          r_axis, n_axis;
    logic [1:0]    r_bsel, n_bsel;
    logic [3:0]    w_n;

    assign w_n = (i_count > 4'(BODY_SLOTS)) ? 4'(BODY_SLOTS) : i_count;

    // next state and command
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_coll  = r_coll;
        n_axis  = r_axis;
        n_bsel  = r_bsel;
        o_cmd.op   = OP_NOP;
        o_cmd.addr = IDX_W'(r_i);
        o_cmd.tgt  = TGT_WVX;
        o_cmd.axis = r_axis;
        o_cmd.last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_action) begin
                        if ({1'b0, i_body_index} < 4'(BODY_SLOTS)) begin
                            o_cmd.op   = OP_LOAD;
                            o_cmd.addr = i_body_index;
                        end
                    end else if (w_n != 4'd0) begin
                        n_n     = CW'(w_n);
                        n_i     = '0;
                        n_coll  = 1'b0;
                        n_state = S_MD;
                    end
                end
            end
            S_MD: begin
                o_cmd.op = OP_MUL_MD;
                n_state  = S_MD2;
            end
            S_MD2: begin
                o_cmd.op = OP_SAVE_MD;
                n_state  = S_GI;
            end
            // gravity pass over body i
            S_GI: begin
                o_cmd.op = OP_LDI;
                n_j      = '0;
                n_state  = S_GJ;
            end
            S_GJ: begin
                if (r_j >= r_n) begin
                    n_state = S_MOVE;
                end else if (r_j == r_i) begin
                    n_j = r_j + CW'(1);
                end else begin
                    o_cmd.op   = OP_LDJ;
                    o_cmd.addr = IDX_W'(r_j);
                    n_state    = S_SQX;
                end
            end
            // squared distance, shared by both passes
            S_SQX: begin
                o_cmd.op = OP_MUL_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = OP_MUL_SQY;
                n_state  = S_SSUM;
            end
            S_SSUM: begin
                o_cmd.op = OP_ADD_S;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (r_coll) begin
                    o_cmd.op = OP_MUL_RR;
                    n_state  = S_CCHK;
                end else if (i_stat.pull_ok) begin
                    o_cmd.op = OP_SQRT;
                    n_state  = S_SQRT;
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = S_GJ;
                end
            end
            S_SQRT: begin
                if (!i_stat.sqrt_busy) begin
                    n_axis  = 1'b0;
                    n_state = S_DVC;
                end
            end
            // three divisions per axis
            S_DVC: begin
                o_cmd.op = OP_DIV_C;
                n_state  = S_DVCW;
            end
            S_DVCW: begin
                if (!i_stat.div_busy) begin
                    n_state = S_MUV;
                end
            end
            S_MUV: begin
                o_cmd.op = OP_MUL_MUV;
                n_state  = S_DVP;
            end
            S_DVP: begin
                o_cmd.op = OP_DIV_P;
                n_state  = S_DVPW;
            end
            S_DVPW: begin
                if (!i_stat.div_busy) begin
                    n_state = S_DVQ;
                end
            end
            S_DVQ: begin
                o_cmd.op = OP_DIV_Q;
                n_state  = S_DVQW;
            end
            S_DVQW: begin
                if (!i_stat.div_busy) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.op = OP_APPLY;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = S_DVC;
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = S_GJ;
                end
            end
            // move and wall bounces
            S_MOVE: begin
                o_cmd.op = OP_MOVE;
                n_state  = S_WALLY;
            end
            S_WALLY: begin
                if (i_stat.wall_y) begin
                    o_cmd.op  = OP_MUL_DAMP;
                    o_cmd.tgt = TGT_WVY;
                    n_state   = S_BNCY;
                end else begin
                    n_state = S_WALLX;
                end
            end
            S_BNCY: begin
                o_cmd.op  = OP_BNC;
                o_cmd.tgt = TGT_WVY;
                n_state   = S_WALLX;
            end
            S_WALLX: begin
                if (i_stat.wall_x) begin
                    o_cmd.op  = OP_MUL_DAMP;
                    o_cmd.tgt = TGT_WVX;
                    n_state   = S_BNCX;
                end else begin
                    n_state = S_WBI;
                end
            end
            S_BNCX: begin
                o_cmd.op  = OP_BNC;
                o_cmd.tgt = TGT_WVX;
                n_state   = S_WBI;
            end
            S_WBI: begin
                o_cmd.op = OP_STORE;
                if (r_i + CW'(1) == r_n) begin
                    n_i     = '0;
                    n_coll  = 1'b1;
                    n_state = S_CI;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_GI;
                end
            end
            // collision pass over pairs i < j
            S_CI: begin
                o_cmd.op = OP_LDI;
                n_j      = r_i + CW'(1);
                n_state  = S_CJ;
            end
            S_CJ: begin
                if (r_j >= r_n) begin
                    n_state = S_CWB;
                end else begin
                    o_cmd.op   = OP_LDJ;
                    o_cmd.addr = IDX_W'(r_j);
                    n_state    = S_SQX;
                end
            end
            S_CCHK: begin
                if (i_stat.hit) begin
                    n_bsel  = 2'd0;
                    n_state = S_CBM;
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = S_CJ;
                end
            end
            S_CBM: begin
                o_cmd.op   = OP_MUL_DAMP;
                o_cmd.tgt  = t_tgt'(r_bsel);
                o_cmd.addr = IDX_W'(r_j);
                n_state    = S_CBW;
            end
            S_CBW: begin
                o_cmd.op   = OP_BNC;
                o_cmd.tgt  = t_tgt'(r_bsel);
                o_cmd.addr = IDX_W'(r_j);
                if (r_bsel == 2'd3) begin
                    n_j     = r_j + CW'(1);
                    n_state = S_CJ;
                end else begin
                    n_bsel  = r_bsel + 2'd1;
                    n_state = S_CBM;
                end
            end
            S_CWB: begin
                o_cmd.op = OP_STORE;
                if (r_i + CW'(1) == r_n) begin
                    n_i     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_CI;
                end
            end
            // one result per body
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op   = OP_EMIT;
                    o_cmd.last = (r_i + CW'(1) == r_n);
                    if (r_i + CW'(1) == r_n) begin
                        n_i     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + CW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_n     <= '0;
            r_coll  <= 1'b0;
            r_axis  <= 1'b0;
            r_bsel  <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_n     <= n_n;
            r_coll  <= n_coll;
            r_axis  <= n_axis;
            r_bsel  <= n_bsel;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // body index stays within the frame while busy
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_i < r_n))
        else $error("body index beyond frame count");

    // a result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_EMIT) |-> i_stat.out_free)
        else $error("result overwritten before transfer");

    // the divider is never restarted mid-division
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_DIV_C || o_cmd.op == OP_DIV_P || o_cmd.op == OP_DIV_Q)
        |-> !i_stat.div_busy)
        else $error("divider started while busy");

    // a body never pairs with itself
    a_no_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_LDJ) |-> (r_j != r_i))
        else $error("body paired with itself");

endmodule

@@ hw/rtl/nbody_gravity_frame_step_core.sv @@
// top level: configuration registers, frame sequencer and datapath
// A load transfer stores one body. A step transfer runs a whole frame before
// its results appear, one result per body in index order, the last flagged.
// Each ordered pair that pulls takes the 33-step square root and, per axis,
// three 64-step divisions on the shared divider that retires one quotient bit
// per cycle; a pair that is too close to pull skips them. The collision tests,
// their hits and the move and wall bounces of each body add further states.
// Input is taken only between frames; the last result may still wait in the
// output register while the next item is taken.
module nbody_gravity_frame_step_core
    import nbfs_pkg::*;
#(
    parameter int MAX_BODIES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // item input
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic [2:0]         i_body_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic [30:0]        i_body_radius,
    input  logic [31:0]        i_pull,
    // result output
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_out_index,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_vel_x,
    output logic signed [31:0] o_out_vel_y,
    output logic               o_last_body
);
    localparam int SLOTS = (MAX_BODIES < RES_CAP) ? MAX_BODIES : RES_CAP;

    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;
    t_reg  w_reg;

    assign w_reg  = t_reg'(paddr[4:2]);
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width    <= 16'd800;
            r_cfg.height   <= 16'd600;
            r_cfg.min_dist <= 31'd65536;
            r_cfg.damping  <= 16'd31130;
            r_cfg.count    <= 4'd2;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_WIDTH:    r_cfg.width    <= pwdata[15:0];
                REG_HEIGHT:   r_cfg.height   <= pwdata[15:0];
                REG_MIN_DIST: r_cfg.min_dist <= pwdata[30:0];
                REG_DAMPING:  r_cfg.damping  <= pwdata[15:0];
                REG_COUNT:    r_cfg.count    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_reg)
            REG_WIDTH:    prdata = {16'h0, r_cfg.width};
            REG_HEIGHT:   prdata = {16'h0, r_cfg.height};
            REG_MIN_DIST: prdata = {1'b0, r_cfg.min_dist};
            REG_DAMPING:  prdata = {16'h0, r_cfg.damping};
            REG_COUNT:    prdata = {28'h0, r_cfg.count};
            default:      prdata = '0;
        endcase
    end

    nbfs_ctrl #(
        .BODY_SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_action     (i_action),
        .i_body_index (i_body_index),
        .i_count      (r_cfg.count),
        .i_stat       (w_stat),
        .o_ready      (o_ready),
        .o_cmd        (w_cmd)
    );

    nbfs_datapath #(
        .BODY_SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg         (r_cfg),
        .o_stat        (w_stat),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_body_radius (i_body_radius),
        .i_pull        (i_pull),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_out_index   (o_out_index),
        .o_out_pos_x   (o_out_pos_x),
        .o_out_pos_y   (o_out_pos_y),
        .o_out_vel_x   (o_out_vel_x),
        .o_out_vel_y   (o_out_vel_y),
        .o_last_body   (o_last_body)
    );

endmodule
